@@ hdl/maes_pkg.sv @@
// Package with the cipher tables, round functions and shared types.
package maes_pkg;

  localparam int NumRounds = 10;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] blk_t;

  // Register index codes for the configuration port.
  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow  = 1'b1;

  // Function codes carried in tuser.
  localparam logic FuncEnc = 1'b0;
  localparam logic FuncDec = 1'b1;

  localparam byte_t SboxTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t RconTab [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Multiply by x in GF(2^8).
  function automatic byte_t xtime(input byte_t a);
    xtime = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
  endfunction

  // General GF(2^8) product; b is a constant at every call site.
  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t p;
    byte_t t;
    p = '0;
    t = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ t;
      t = xtime(t);
    end
    gf_mul = p;
  endfunction

  // Forward substitution: S(x*2 xor 1).
  function automatic byte_t sub_fwd(input byte_t x);
    sub_fwd = SboxTab[xtime(x) ^ 8'h01];
  endfunction

  // Inverse S-box: searches the forward table for the entry equal to y.
  function automatic byte_t sbox_inv(input byte_t y);
    byte_t t;
    t = '0;
    for (int v = 0; v < 256; v++) begin
      if (SboxTab[v] == y) t = byte_t'(v);
    end
    sbox_inv = t;
  endfunction

  // Undo the affine pre-map t = x*2 xor 1.
  function automatic byte_t unmap(input byte_t t);
    unmap = t[0] ? {1'b0, t[7:1]} : ({1'b0, t[7:1]} ^ 8'h8d);
  endfunction

  // Byte i of a block, byte 0 most significant.
  function automatic byte_t get_b(input blk_t s, input int i);
    get_b = s[127-8*i -: 8];
  endfunction

  function automatic blk_t shift_rows(input blk_t s, input logic dir);
    blk_t o;
    o = s;
    for (int r = 1; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[127-8*(4*c+r) -: 8] = get_b(s, 4*(dir ? ((c+4-r)&3) : ((c+r)&3)) + r);
      end
    end
    shift_rows = o;
  endfunction

  function automatic blk_t mix_fwd(input blk_t s);
    blk_t o;
    byte_t m [4];
    m = '{8'h01, 8'h04, 8'h04, 8'h05};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        byte_t acc;
        acc = '0;
        for (int k = 0; k < 4; k++) acc = acc ^ gf_mul(get_b(s, 4*c+k), m[(k+4-r)&3]);
        o[127-8*(4*c+r) -: 8] = acc;
      end
    end
    mix_fwd = o;
  endfunction

  function automatic blk_t mix_inv(input blk_t s);
    blk_t o;
    byte_t m [4];
    m = '{8'ha5, 8'h07, 8'h1a, 8'h73};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        byte_t acc;
        acc = '0;
        for (int k = 0; k < 4; k++) acc = acc ^ gf_mul(get_b(s, 4*c+k), m[(k+4-r)&3]);
        o[127-8*(4*c+r) -: 8] = acc;
      end
    end
    mix_inv = o;
  endfunction

  // One step of the key expansion.
  function automatic blk_t next_key(input blk_t p, input byte_t rc);
    blk_t k;
    byte_t t [4];
    t[0] = SboxTab[get_b(p, 13)] ^ rc;
    t[1] = SboxTab[get_b(p, 14)];
    t[2] = SboxTab[get_b(p, 15)];
    t[3] = SboxTab[get_b(p, 12)];
    for (int i = 0; i < 4; i++) k[127-8*i -: 8] = get_b(p, i) ^ t[i];
    for (int i = 4; i < 16; i++) k[127-8*i -: 8] = get_b(p, i) ^ k[127-8*(i-4) -: 8];
    next_key = k;
  endfunction

  // Pipeline stage control travelling with the data.
  typedef struct packed {
    logic valid;
    logic func;
  } stage_ctl_t;

endpackage

@@ hdl/maes_keysched.sv @@
// Key schedule: registers the eleven round keys after each key write.
module maes_keysched
  import maes_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [0:0] wr_index,
  input  logic [63:0] wr_data,
  output blk_t rk [NumRounds+1]
);

  logic [63:0] key_high;
  logic [63:0] key_low;

  // Key registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        RegKeyHigh: key_high <= wr_data;
        RegKeyLow:  key_low  <= wr_data;
        default: ;
      endcase
    end
  end

  // Expansion chain, one register per round key; it settles while the top level keeps its input closed.
  always_ff @(posedge clk) begin
    rk[0] <= {key_high, key_low};
    for (int r = 1; r <= NumRounds; r++) rk[r] <= next_key(rk[r-1], RconTab[r-1]);
  end

endmodule

@@ hdl/maes_round.sv @@
// One cipher round stage for both directions, with stall support.
module maes_round
  import maes_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic first,
  input  logic last,
  input  blk_t key_enc,
  input  blk_t key_dec,
  input  stage_ctl_t ctl_in,
  input  blk_t din,
  output stage_ctl_t ctl_out,
  output blk_t dout
);

  blk_t enc_v;
  blk_t dec_v;
  blk_t t;

  // Forward: sub, shift, mix, add key. Inverse: add key, mix, shift, sub.
  // The forward direction skips the mix in its last round, the inverse one in its first.
  always_comb begin
    for (int i = 0; i < 16; i++) t[127-8*i -: 8] = sub_fwd(get_b(din, i));
    t = shift_rows(t, 1'b0);
    enc_v = (last ? t : mix_fwd(t)) ^ key_enc;
    t = din ^ key_dec;
    t = shift_rows(first ? t : mix_inv(t), 1'b1);
    for (int i = 0; i < 16; i++) dec_v[127-8*i -: 8] = unmap(sbox_inv(get_b(t, i)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= (ctl_in.func == FuncDec) ? dec_v : enc_v;
  end

endmodule

@@ hdl/modified_aes128_block_cipher_top.sv @@
// Beats pass the entry stage and ten round stages; the last is the output register.
// Throughput: one block per cycle; all stages stall while an output beat waits.
// After reset or a key write, s_tready stays low while the round keys settle.
// Reset is synchronous: it clears the keys and all pipeline valid bits.
// s_tready follows m_tready or an empty output slot once the keys have settled.
module modified_aes128_block_cipher_top
  import maes_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [127:0] s_tdata,   // block_high[63:0], block_low[127:64]
  input  logic s_tuser,           // func
  output logic m_tvalid,
  input  logic m_tready,
  output logic [127:0] m_tdata,   // out_high[63:0], out_low[127:64]
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [63:0] cfg_data
);

  blk_t rk [NumRounds+1];
  stage_ctl_t ctl [NumRounds+1];
  blk_t st [NumRounds+1];
  blk_t in_blk;
  blk_t res;
  logic en;
  logic [3:0] settle;

  assign cfg_ready = 1'b1;

  maes_keysched u_keys (
    .clk(clk), .rst(rst), .wr_en(cfg_valid), .wr_index(cfg_index),
    .wr_data(cfg_data), .rk(rk)
  );

  // Hold the input closed until the round key chain has caught up with the keys.
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 4'(NumRounds);
    end else if (cfg_valid && cfg_ready) begin
      settle <= 4'(NumRounds);
    end else if (settle != '0) begin
      settle <= settle - 4'd1;
    end
  end

  // Whole-pipe advance when the output slot frees or is empty.
  assign en = m_tready || !ctl[NumRounds].valid;
  assign s_tready = en && (settle == '0);

  assign in_blk = {s_tdata[63:0], s_tdata[127:64]};

  // Entry stage: initial key add for encryption.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (en) begin
      ctl[0] <= '{valid: s_tvalid && s_tready, func: s_tuser};
    end
  end

  always_ff @(posedge clk) begin
    if (en) st[0] <= (s_tuser == FuncDec) ? in_blk : (in_blk ^ rk[0]);
  end

  // Ten round stages.
  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    maes_round u_round (
      .clk(clk), .rst(rst), .en(en), .first(g == 1), .last(g == NumRounds),
      .key_enc(rk[g]), .key_dec(rk[NumRounds+1-g]),
      .ctl_in(ctl[g-1]), .din(st[g-1]), .ctl_out(ctl[g]), .dout(st[g])
    );
  end

  assign m_tvalid = ctl[NumRounds].valid;
  assign res      = (ctl[NumRounds].func == FuncDec) ? (st[NumRounds] ^ rk[0]) : st[NumRounds];
  assign m_tdata  = {res[63:0], res[127:64]};

endmodule

@@ hdl/maes_checker.sv @@
// Port-level checker for the cipher top level, with its bind.
module maes_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [127:0] m_tdata
);

  // A held output beat keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output changed");

  // The input side is closed while a result waits at the output.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready) else $error("input open during stall");

  // Nothing leaves right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid after reset");

  // An accepted beat reaches the output through the entry and round stages when m_tready stays high meanwhile.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready ##1 m_tready [*10] |=> m_tvalid) else $error("latency");

endmodule

bind modified_aes128_block_cipher_top maes_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
